// ----- hw/rtl/ucdw_pkg.sv -----
`timescale 1ns / 1ps

package ucdw_pkg;

  localparam logic [7:0] MIN_DESC_LEN   = 8'd3;
  localparam logic [7:0] MIN_FIRST_LEN  = 8'd4;
  localparam logic [7:0] TYPE_CONFIG    = 8'd2;
  localparam logic [7:0] TYPE_IFACE     = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
  localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
  localparam logic [7:0] EP_MIN_LEN     = 8'd7;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_END       = 2'd1,
    ST_TOO_SHORT = 2'd2,
    ST_OVERRUN   = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
  } item_t;

  typedef struct packed {
    logic [7:0]  desc_type;
    logic [15:0] desc_offset;
    logic [7:0]  desc_length;
    logic        is_interface;
    logic        is_endpoint;
    logic [7:0]  iface_number;
    logic [7:0]  iface_seq;
    logic [7:0]  alt_index;
    logic        endpoint_run_end;
    status_t     status;
    logic        last;
  } result_t;

endpackage

// ----- hw/rtl/ucdw_if.sv -----
`timescale 1ns / 1ps

interface ucdw_in_if import ucdw_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
  modport mon    (input valid, input payload, input ready);
endinterface

interface ucdw_out_if import ucdw_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
  modport mon    (input valid, input payload, input ready);
endinterface

// ----- hw/rtl/ucdw_in_stage.sv -----
`timescale 1ns / 1ps

module ucdw_in_stage import ucdw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  valid,
  output item_t item
);

  logic load;

  assign in_ready = !valid || advance;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// ----- hw/rtl/ucdw_parser.sv -----
`timescale 1ns / 1ps

module ucdw_parser import ucdw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  logic    advance,
  output result_t result,
  output logic    has_result
);

  logic [15:0] byte_offset;
  logic [15:0] total_length;
  logic        total_known;
  logic [15:0] cur_start;
  logic [7:0]  cur_length;
  logic [7:0]  cur_type;
  logic [7:0]  cur_iface_number;
  logic [7:0]  last_iface_number;
  logic [7:0]  iface_count_index;
  logic [7:0]  alt_count_index;
  logic        seen_interface;
  logic        stopped;

  // state as seen by this byte: a first byte starts from a clean slate
  logic [15:0] off, start_e, total_e, pos;
  logic        known_e, seen_e, active;
  logic [7:0]  len_e, type_e, ifn_e, last_ifn_e, iidx_e, aidx_e;
  logic [7:0]  b;

  logic [15:0] total_length_next;
  logic        total_known_next;
  logic [7:0]  cur_length_next, cur_type_next, cur_iface_number_next;
  logic [7:0]  iface_count_index_next, alt_count_index_next;
  logic        seen_interface_next;

  logic        err, done, at_end, is_if, is_ep, run_end;
  status_t     err_status;

  always_comb begin
    b          = item.data_byte;
    active     = item.first || !stopped;
    off        = item.first ? '0 : byte_offset;
    start_e    = item.first ? '0 : cur_start;
    total_e    = item.first ? '0 : total_length;
    known_e    = item.first ? 1'b0 : total_known;
    len_e      = item.first ? '0 : cur_length;
    type_e     = item.first ? '0 : cur_type;
    ifn_e      = item.first ? '0 : cur_iface_number;
    last_ifn_e = item.first ? '0 : last_iface_number;
    iidx_e     = item.first ? '0 : iface_count_index;
    aidx_e     = item.first ? '0 : alt_count_index;
    seen_e     = item.first ? 1'b0 : seen_interface;
    pos        = off - start_e;
  end

  // field capture within the current descriptor and the total length
  always_comb begin
    cur_length_next       = (pos == 16'd0) ? b : len_e;
    cur_type_next         = (pos == 16'd0) ? 8'd0 : (pos == 16'd1) ? b : type_e;
    cur_iface_number_next = (pos == 16'd0) ? 8'd0 : (pos == 16'd2) ? b : ifn_e;
    if (off == 16'd2) begin
      total_length_next = {8'd0, b};
    end else if (off == 16'd3) begin
      total_length_next = {b, total_e[7:0]};
    end else begin
      total_length_next = total_e;
    end
    total_known_next = known_e || (off == 16'd3);
  end

  // stop conditions, in order of precedence
  always_comb begin
    err        = 1'b1;
    err_status = ST_OK;
    priority if (pos == 16'd0 && off == 16'd0 && b < MIN_FIRST_LEN) begin
      err_status = ST_TOO_SHORT;
    end else if (pos == 16'd0 && off != 16'd0 && known_e &&
                 ({1'b0, start_e} + {9'd0, b} > {1'b0, total_e})) begin
      err_status = ST_OVERRUN;
    end else if (pos == 16'd0 && off != 16'd0 && b < MIN_DESC_LEN) begin
      err_status = ST_TOO_SHORT;
    end else if (off == 16'd3 && total_length_next == 16'd0) begin
      err_status = ST_END;
    end else if (off == 16'd3 && {8'd0, cur_length_next} > total_length_next) begin
      err_status = ST_OVERRUN;
    end else begin
      err = 1'b0;
    end
  end

  always_comb begin
    done    = !err && ({1'b0, pos} + 17'd1 == {9'd0, cur_length_next});
    at_end  = total_known_next && ({1'b0, off} + 17'd1 == {1'b0, total_length_next});
    is_if   = cur_type_next == TYPE_IFACE && cur_length_next >= IFACE_MIN_LEN;
    is_ep   = cur_type_next == TYPE_ENDPOINT && cur_length_next >= EP_MIN_LEN;
    run_end = cur_type_next == TYPE_CONFIG ||
              (cur_type_next == TYPE_ENDPOINT && cur_length_next < EP_MIN_LEN);

    iface_count_index_next = iidx_e;
    alt_count_index_next   = aidx_e;
    seen_interface_next    = seen_e;
    if (is_if) begin
      if (!seen_e) begin
        seen_interface_next = 1'b1;
      end else if (cur_iface_number_next == last_ifn_e) begin
        alt_count_index_next = aidx_e + 8'd1;
      end else begin
        iface_count_index_next = iidx_e + 8'd1;
        alt_count_index_next   = 8'd0;
      end
    end
  end

  always_comb begin
    has_result         = active && (err || done);
    result.desc_type   = cur_type_next;
    result.desc_offset = start_e;
    result.desc_length = cur_length_next;
    if (err) begin
      result.is_interface     = 1'b0;
      result.is_endpoint      = 1'b0;
      result.iface_number     = 8'd0;
      result.iface_seq        = iidx_e;
      result.alt_index        = aidx_e;
      result.endpoint_run_end = 1'b0;
      result.status           = err_status;
      result.last             = 1'b1;
    end else begin
      result.is_interface     = is_if;
      result.is_endpoint      = is_ep;
      result.iface_number     = is_if ? cur_iface_number_next : 8'd0;
      result.iface_seq        = iface_count_index_next;
      result.alt_index        = alt_count_index_next;
      result.endpoint_run_end = run_end;
      result.status           = at_end ? ST_END : ST_OK;
      result.last             = at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset       <= '0;
      total_length      <= '0;
      total_known       <= 1'b0;
      cur_start         <= '0;
      cur_length        <= '0;
      cur_type          <= '0;
      cur_iface_number  <= '0;
      last_iface_number <= '0;
      iface_count_index <= '0;
      alt_count_index   <= '0;
      seen_interface    <= 1'b0;
      stopped           <= 1'b1;
    end else if (advance && active) begin
      byte_offset      <= off + 16'd1;
      total_length     <= total_length_next;
      total_known      <= total_known_next;
      cur_length       <= cur_length_next;
      cur_type         <= cur_type_next;
      cur_iface_number <= cur_iface_number_next;
      stopped          <= err || (done && at_end);
      if (done) begin
        cur_start         <= off + 16'd1;
        iface_count_index <= iface_count_index_next;
        alt_count_index   <= alt_count_index_next;
        seen_interface    <= seen_interface_next;
        if (is_if) begin
          last_iface_number <= cur_iface_number_next;
        end
      end else begin
        cur_start         <= start_e;
        iface_count_index <= iidx_e;
        alt_count_index   <= aidx_e;
        seen_interface    <= seen_e;
        last_iface_number <= last_ifn_e;
      end
    end
  end

endmodule

// ----- hw/rtl/ucdw_out_stage.sv -----
`timescale 1ns / 1ps

module ucdw_out_stage import ucdw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_result
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= load_result;
    end
  end

endmodule

// ----- hw/rtl/usb_config_descriptor_walker.sv -----
`timescale 1ns / 1ps
// Path: the byte that completes (or stops) a descriptor waits in the input register, and its
//   result is loaded into the result register when that byte advances, then offered from there.
// Throughput: one byte per cycle, sustained while results are taken as offered.
// Reset (rst, synchronous): empties both registers and leaves the walker stopped until
//   a byte with first set arrives; bytes without first are dropped while stopped.

module usb_config_descriptor_walker import ucdw_pkg::*; (
  input logic       clk,
  input logic       rst,
  ucdw_in_if.sink   in_ch,
  ucdw_out_if.source out_ch
);

  logic    s1_valid;
  item_t   s1_item;
  logic    out_free;
  logic    advance;
  result_t step_result;
  logic    step_has_result;

  // The byte in the input register moves on whenever the result register can take
  // whatever it produces; bytes that complete nothing still retire at that point.
  assign advance = s1_valid && out_free;

  // Input register: holds one byte; refills in the same cycle it retires.
  ucdw_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_item  (in_ch.payload),
    .advance  (advance),
    .valid    (s1_valid),
    .item     (s1_item)
  );

  // Parse state plus the single-pass step logic; state advances with the byte.
  ucdw_parser u_parse (
    .clk        (clk),
    .rst        (rst),
    .item       (s1_item),
    .advance    (advance),
    .result     (step_result),
    .has_result (step_has_result)
  );

  // Result register: load only bytes that produce a report.
  ucdw_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && step_has_result),
    .load_result (step_result),
    .free        (out_free),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_result  (out_ch.payload)
  );

endmodule

// ----- hw/rtl/ucdw_checker.sv -----
`timescale 1ns / 1ps

module ucdw_checker import ucdw_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    valid,
  input logic    ready,
  input result_t result
);

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result offered after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(result))
    else $error("result dropped or changed while stalled");

  // last goes with a nonzero status and only then
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    valid |-> (result.last == (result.status != ST_OK)))
    else $error("last and status disagree");

  // an interface report carries a matching type and length
  a_iface_class: assert property (@(posedge clk) disable iff (rst)
    valid && result.is_interface |->
      result.desc_type == TYPE_IFACE &&
      result.desc_length >= IFACE_MIN_LEN && !result.is_endpoint)
    else $error("bad interface classification");

  // stop reports on errors carry no classification
  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    valid && (result.status == ST_TOO_SHORT || result.status == ST_OVERRUN) |->
      !result.is_interface && !result.is_endpoint &&
      !result.endpoint_run_end && result.iface_number == 8'd0)
    else $error("error report carries classification");

endmodule

bind usb_config_descriptor_walker ucdw_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .valid  (out_ch.valid),
  .ready  (out_ch.ready),
  .result (out_ch.payload)
);
